// ----- rtl/lrn_across_channels_macros.svh -----
// ----------------------------------------------------------------------------
// lrn_across_channels assertion macros
// Concurrent assertion shorthands; the using module provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef LRN_ACROSS_CHANNELS_MACROS_SVH
`define LRN_ACROSS_CHANNELS_MACROS_SVH

// same-cycle implication
`define LRN_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRN_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lrn_pkg.sv -----
// ----------------------------------------------------------------------------
// lrn_pkg
// Shared types, constants and tables of the channel-wise LRN block.
// ----------------------------------------------------------------------------
package lrn_pkg;

  localparam int DEF_MAX_WINDOW  = 15;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int WS_W       = 4;
  localparam int ALPHA_W    = 24;
  localparam int BETA_W     = 16;
  localparam int HALF_W     = 3;
  localparam int HALF_CAP   = 7;
  localparam int CHUNK_W    = 16;

  localparam logic [WS_W-1:0]    WS_RESET    = 4'd5;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 24'd336;
  localparam logic [BETA_W-1:0]  BETA_RESET  = 16'd12288;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_ALPHA  = 2'd1,
    CFG_BETA   = 2'd2
  } cfg_idx_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_UPDATE = 11'b00000000010,
    ST_MLOAD  = 11'b00000000100,
    ST_MUL    = 11'b00000001000,
    ST_SLOAD  = 11'b00000010000,
    ST_NORM   = 11'b00000100000,
    ST_LOG    = 11'b00001000000,
    ST_POW    = 11'b00010000000,
    ST_EXP    = 11'b00100000000,
    ST_PROD   = 11'b01000000000,
    ST_OUTW   = 11'b10000000000
  } lrn_state_t;

  typedef struct packed {
    logic take_in;
    logic shift_in;
    logic shift_zero;
    logic clear;
    logic mul_start;
    logic mul_step;
    logic s_load;
    logic s_shift;
    logic log_calc;
    logic pow_calc;
    logic exp_calc;
    logic prod_calc;
    logic out_load;
    logic out_last;
  } lrn_cmd_t;

  typedef struct packed {
    logic [HALF_W-1:0] half;
    logic              s_msb;
    logic              out_free;
    logic              win_write;
  } lrn_status_t;

  function automatic int sum_width(int vw, int mw);
    return 2 * vw + $clog2(mw + 1);
  endfunction

  function automatic int chunk_count(int vw, int mw);
    return (sum_width(vw, mw) + CHUNK_W - 1) / CHUNK_W;
  endfunction

  // log2(1 + k/16), Q1.16
  function automatic logic [16:0] log_entry(logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = '0;
    endcase
    return v;
  endfunction

  // 2^(k/16), Q2.16
  function automatic logic [17:0] exp_entry(logic [4:0] k);
    logic [17:0] v;
    case (k)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      5'd16: v = 18'd131072;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lrn_ifs.sv -----
// ----------------------------------------------------------------------------
// lrn channel interfaces
// Valid/ready channels for activations, results and register writes.
// ----------------------------------------------------------------------------
interface lrn_in_if import lrn_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] activation;
  logic                          last_channel;
  modport source (output valid, activation, last_channel, input ready);
  modport sink (input valid, activation, last_channel, output ready);
endinterface

interface lrn_out_if import lrn_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] normalized;
  logic                          last_of_run;
  modport source (output valid, normalized, last_of_run, input ready);
  modport sink (input valid, normalized, last_of_run, output ready);
endinterface

interface lrn_cfg_if import lrn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/lrn_across_channels.sv -----
// ----------------------------------------------------------------------------
// lrn_across_channels
// Channel-wise local response normalization, one spatial position at a time.
// ----------------------------------------------------------------------------
//  in_ch  : Q8.8 activations in channel order, last_channel on the final one.
//  out_ch : one normalized value per input, last_of_run on the final one.
//  cfg    : writes to 0 window_size, 1 alpha_over_size, 2 beta_exponent;
//           always ready, write only while idle; window_size drops the position.
//  Results lag the inputs by half the window; the flagged input drains the
//  trailing channels, one window update each plus the normalize steps when
//  that channel yields a result.
//  An input is accepted, then updates the window; a result adds a multiply
//  load, NCH multiply steps, a sum load, 0 to 10 leading-one shift steps
//  (4 bits or 1 per step), then log, power, exp, product and output write,
//  NCH being the 16-bit chunks of the square sum (3 at default widths).
//  One item at a time; a finished result waits in the output register while
//  the next channel is processed, stalling only in front of a full register.
//  Reset (rst, synchronous) restores the registers to 5, 336, 12288 and
//  clears window, sum and counts.
// ----------------------------------------------------------------------------
module lrn_across_channels import lrn_pkg::*; #(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  lrn_in_if.sink     in_ch,
  lrn_out_if.source  out_ch,
  lrn_cfg_if.sink    cfg
);

  lrn_cmd_t    cmd;
  lrn_status_t status;

  assign cfg.ready = 1'b1;

  lrn_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .last_channel(in_ch.last_channel),
    .cmd         (cmd),
    .status      (status)
  );

  lrn_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .activation (in_ch.activation),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .normalized (out_ch.normalized),
    .last_of_run(out_ch.last_of_run)
  );

endmodule

// ----- rtl/lrn_datapath.sv -----
// ----------------------------------------------------------------------------
// lrn_datapath
// Registers, channel window, running square sum and the normalizing
// arithmetic (chunked multiply, leading-one shift, log2/exp2 tables).
// ----------------------------------------------------------------------------
module lrn_datapath import lrn_pkg::*; #(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lrn_cmd_t                      cmd,
  output lrn_status_t                   status,
  input  logic signed [VALUE_WIDTH-1:0] activation,
  input  logic                          cfg_valid,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] normalized,
  output logic                          last_of_run
);

  localparam int VW      = VALUE_WIDTH;
  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W   = sum_width(VW, MAX_WINDOW);
  localparam int NCH     = chunk_count(VW, MAX_WINDOW);
  localparam int SUMP_W  = NCH * CHUNK_W;
  localparam int ACC_W   = SUMP_W + ALPHA_W;
  localparam int S_W     = SUMP_W + 1;
  localparam int SH_W    = $clog2(S_W);
  localparam int IPMAX   = S_W - 17;
  localparam int IP_W    = $clog2(IPMAX + 1);
  localparam int LG_W    = IP_W + 16;
  localparam int Y_W     = LG_W + 2;
  localparam int N_W     = Y_W - 16;
  localparam int PR_W    = VW + 18;
  localparam int WIN_CAP = (MAX_WINDOW - 1) / 2;
  localparam int HCAP    = (WIN_CAP < HALF_CAP) ? WIN_CAP : HALF_CAP;
  localparam logic [PR_W-1:0] HALF_RANGE = PR_W'(1) << (VW - 1);
  localparam logic [PR_W-1:0] LIM        = HALF_RANGE - PR_W'(1);

  logic [WS_W-1:0]    window_size;
  logic [ALPHA_W-1:0] alpha_over_size;
  logic [BETA_W-1:0]  beta_exponent;
  logic               win_write;

  logic [WS_W-1:0]   half_raw;
  logic [HALF_W-1:0] half;

  logic signed [VW-1:0] x_reg;
  logic signed [VW-1:0] recent [MAX_WINDOW];
  logic signed [VW-1:0] x_new;
  logic signed [VW-1:0] x_old;
  logic signed [2*VW-1:0] sq_new;
  logic signed [2*VW-1:0] sq_old;
  logic [SUM_W-1:0] square_sum;

  logic signed [VW-1:0] xsel;
  logic [SUMP_W-1:0]    sum_sh;
  logic [ACC_W-1:0]     acc;
  logic [ALPHA_W+CHUNK_W-1:0] part;

  logic [S_W-1:0]  s;
  logic [SH_W-1:0] shifts;
  logic            top_zero;

  logic [IP_W-1:0] ip;
  logic [15:0]     frac;
  logic [16:0]     l0, l1, ldiff;
  logic [28:0]     lprod;
  logic [LG_W-1:0] lg;

  logic [BETA_W+LG_W-1:0] yfull;
  logic [Y_W-1:0]         y;
  logic [16:0]            t;
  logic [4:0]             ei;
  logic [17:0]            e0, e1, ediff;
  logic [29:0]            eprod;
  logic [17:0]            pw;

  logic [VW-1:0]   mag;
  logic [PR_W-1:0] prod;
  logic [PR_W-1:0] q;
  logic [PR_W-1:0] res;
  logic [PR_W-1:0] res_neg;
  logic [VW-1:0]   value;

  // registers
  assign win_write = cfg_valid && (cfg_index == CFG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size     <= WS_RESET;
      alpha_over_size <= ALPHA_RESET;
      beta_exponent   <= BETA_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW: window_size     <= cfg_data[WS_W-1:0];
        CFG_ALPHA:  alpha_over_size <= cfg_data[ALPHA_W-1:0];
        CFG_BETA:   beta_exponent   <= cfg_data[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  assign half_raw = (window_size == '0) ? '0 : ((window_size - 1'b1) >> 1);
  assign half = (half_raw > WS_W'(HCAP)) ? HALF_W'(HCAP) : half_raw[HALF_W-1:0];

  // window and running sum
  assign x_new  = cmd.shift_zero ? '0 : x_reg;
  assign x_old  = recent[IDX_W'({half, 1'b0})];
  assign sq_new = x_new * x_new;
  assign sq_old = x_old * x_old;

  always_ff @(posedge clk) begin
    if (cmd.take_in) x_reg <= activation;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear || win_write) begin
      for (int i = 0; i < MAX_WINDOW; i++) recent[i] <= '0;
      square_sum <= '0;
    end else if (cmd.shift_in) begin
      for (int i = MAX_WINDOW - 1; i > 0; i--) recent[i] <= recent[i-1];
      recent[0]  <= x_new;
      square_sum <= square_sum + SUM_W'($unsigned(sq_new)) - SUM_W'($unsigned(sq_old));
    end
  end

  // alpha * sum, one 16-bit chunk per cycle, high chunk first
  assign part = alpha_over_size * sum_sh[SUMP_W-1 -: CHUNK_W];

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      xsel   <= recent[IDX_W'(half)];
      sum_sh <= SUMP_W'(square_sum);
      acc    <= '0;
    end else if (cmd.mul_step) begin
      acc    <= {acc[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(part);
      sum_sh <= sum_sh << CHUNK_W;
    end
  end

  // leading-one normalization, a nibble or a bit per cycle
  assign top_zero = (s[S_W-1 -: 4] == 4'd0);

  always_ff @(posedge clk) begin
    if (cmd.s_load) begin
      s      <= S_W'(17'h10000) + S_W'(acc[ACC_W-1:ALPHA_W]);
      shifts <= '0;
    end else if (cmd.s_shift) begin
      if (top_zero) begin
        s      <= s << 4;
        shifts <= shifts + SH_W'(4);
      end else begin
        s      <= s << 1;
        shifts <= shifts + SH_W'(1);
      end
    end
  end

  // log2
  assign ip    = IP_W'(IPMAX) - IP_W'(shifts);
  assign frac  = s[S_W-2 -: 16];
  assign l0    = log_entry({1'b0, frac[15:12]});
  assign l1    = log_entry(5'({1'b0, frac[15:12]} + 5'd1));
  assign ldiff = l1 - l0;
  assign lprod = ldiff * frac[11:0];

  always_ff @(posedge clk) begin
    if (cmd.log_calc) lg <= {ip, 16'h0000} + LG_W'(l0) + LG_W'(lprod[28:12]);
  end

  // beta * log2
  assign yfull = beta_exponent * lg;

  always_ff @(posedge clk) begin
    if (cmd.pow_calc) y <= yfull[BETA_W+LG_W-1:14];
  end

  // 2^(1-g)
  assign t     = 17'h10000 - {1'b0, y[15:0]};
  assign ei    = t[16:12];
  assign e0    = exp_entry(ei);
  assign e1    = exp_entry(5'(ei + 5'd1));
  assign ediff = e1 - e0;
  assign eprod = ediff * t[11:0];

  always_ff @(posedge clk) begin
    if (cmd.exp_calc) pw <= e0 + eprod[29:12];
  end

  assign mag = xsel[VW-1] ? VW'(-xsel) : VW'(xsel);

  always_ff @(posedge clk) begin
    if (cmd.prod_calc) prod <= PR_W'(mag) * PR_W'(pw);
  end

  // round half up, shift by 17 + n, saturate
  assign q       = (prod >> 16) >> y[Y_W-1:16];
  assign res     = (q + PR_W'(1)) >> 1;
  assign res_neg = (res > HALF_RANGE) ? HALF_RANGE : res;

  always_comb begin
    if (xsel[VW-1]) value = VW'(-res_neg);
    else            value = (res > LIM) ? LIM[VW-1:0] : res[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      normalized  <= value;
      last_of_run <= cmd.out_last;
    end
  end

  assign status.half      = half;
  assign status.s_msb     = s[S_W-1];
  assign status.out_free  = !out_valid || out_ready;
  assign status.win_write = win_write;

endmodule

// ----- rtl/lrn_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrn_ctrl
// Sequencer: input handshake, window update, drain of trailing channels,
// and the step order of the normalizing datapath.
// ----------------------------------------------------------------------------
`include "lrn_across_channels_macros.svh"

module lrn_ctrl import lrn_pkg::*; #(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        last_channel,
  output lrn_cmd_t    cmd,
  input  lrn_status_t status
);

  localparam int NCH   = chunk_count(VALUE_WIDTH, MAX_WINDOW);
  localparam int CNT_W = $clog2(NCH + 1);

  lrn_state_t        state, state_next;
  logic [HALF_W-1:0] pending, pending_next;
  logic [HALF_W-1:0] k, k_next;
  logic              draining, draining_next;
  logic              last_reg;
  logic              out_last_reg;
  logic [CNT_W-1:0]  cnt;

  logic              emit_now;
  logic              out_last_next;
  logic              adv_clear;
  lrn_state_t        adv_state;
  logic [HALF_W-1:0] adv_k;
  logic              adv_draining;

  assign emit_now = draining ? (k > (status.half - pending)) : (pending >= status.half);
  assign out_last_next = last_reg && (draining ? (k == status.half) : (status.half == '0));

  // what follows once the current channel is done
  always_comb begin
    adv_clear    = 1'b0;
    adv_k        = k;
    adv_draining = draining;
    adv_state    = ST_IDLE;
    if (draining && (k < status.half)) begin
      adv_k     = k + 1'b1;
      adv_state = ST_UPDATE;
    end else if (!draining && last_reg && (status.half != '0)) begin
      adv_draining = 1'b1;
      adv_k        = HALF_W'(1);
      adv_state    = ST_UPDATE;
    end else if (last_reg) begin
      adv_clear    = 1'b1;
      adv_draining = 1'b0;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    pending_next  = pending;
    k_next        = k;
    draining_next = draining;
    in_ready      = 1'b0;
    cmd.shift_zero = draining;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.shift_in = 1'b1;
        if (emit_now) begin
          state_next = ST_MLOAD;
        end else begin
          if (!draining) pending_next = pending + 1'b1;
          cmd.clear     = adv_clear;
          state_next    = adv_state;
          k_next        = adv_k;
          draining_next = adv_draining;
        end
      end
      ST_MLOAD: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == CNT_W'(NCH - 1)) state_next = ST_SLOAD;
      end
      ST_SLOAD: begin
        cmd.s_load = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (status.s_msb) state_next = ST_LOG;
        else              cmd.s_shift = 1'b1;
      end
      ST_LOG: begin
        cmd.log_calc = 1'b1;
        state_next   = ST_POW;
      end
      ST_POW: begin
        cmd.pow_calc = 1'b1;
        state_next   = ST_EXP;
      end
      ST_EXP: begin
        cmd.exp_calc = 1'b1;
        state_next   = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod_calc = 1'b1;
        state_next    = ST_OUTW;
      end
      ST_OUTW: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_last  = out_last_reg;
          cmd.clear     = adv_clear;
          state_next    = adv_state;
          k_next        = adv_k;
          draining_next = adv_draining;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.clear || status.win_write) begin
      pending_next  = '0;
      draining_next = 1'b0;
      k_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= '0;
      k        <= '0;
      draining <= 1'b0;
    end else begin
      state    <= state_next;
      pending  <= pending_next;
      k        <= k_next;
      draining <= draining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) last_reg <= last_channel;
    if ((state == ST_UPDATE) && emit_now) out_last_reg <= out_last_next;
    if (cmd.mul_start) cnt <= '0;
    else if (cmd.mul_step) cnt <= cnt + 1'b1;
  end

  `LRN_ASSERT_IMP(a_pending_le_half, 1'b1, pending <= status.half, "pending above half width")
  `LRN_ASSERT_IMP(a_drain_range, draining, (k != '0) && (k <= status.half), "drain step out of range")
  `LRN_ASSERT_NXT(a_take_update, cmd.take_in, state == ST_UPDATE, "accepted item not updated")
  `LRN_ASSERT_IMP(a_load_free, cmd.out_load, status.out_free, "output register overwritten")

endmodule

// ----- sim/tb_lrn_across_channels.sv -----
// ----------------------------------------------------------------------------
// tb_lrn_across_channels
// Streams channel runs through the LRN block under several register settings
// and random handshake gaps, predicts each normalized value in the bench and
// compares every result item in order.
// ----------------------------------------------------------------------------
module tb_lrn_across_channels;
  import lrn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrn_in_if  in_ch ();
  lrn_out_if out_ch ();
  lrn_cfg_if cfg ();

  lrn_across_channels u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               last_of_run;
  } lrn_result_t;

  lrn_result_t expected_q[$];

  logic [3:0]  win_reg;
  logic [23:0] alpha_reg;
  logic [15:0] beta_reg;
  logic signed [15:0] window_vals [15];
  logic [63:0] sq_sum;
  int unsigned pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;

  function automatic logic [31:0] log_tbl(int k);
    int unsigned t[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                           42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    return t[k];
  endfunction

  function automatic logic [31:0] exp_tbl(int k);
    int unsigned t[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                           92682, 96785, 101070, 105545, 110218, 115098, 120194,
                           125515, 131072};
    return t[k];
  endfunction

  function automatic int unsigned half_of_window();
    int unsigned h;
    h = (win_reg == 0) ? 0 : (win_reg - 1) >> 1;
    if (h > 7) h = 7;
    return h;
  endfunction

  function automatic logic signed [15:0] normalize_value(logic signed [15:0] x);
    logic [63:0] s, frac, rem, lg, y, n, g, t, pw, mag, res, shift;
    int p, idx;
    s = 64'd65536 + ((64'(alpha_reg) * sq_sum) >> 24);
    p = 63;
    while (p > 16 && !s[p]) p--;
    frac = (s >> (p - 16)) & 64'hFFFF;
    idx = int'(frac >> 12);
    rem = frac & 64'hFFF;
    lg = (64'(p - 16) << 16) + log_tbl(idx) + ((64'(log_tbl(idx + 1) - log_tbl(idx)) * rem) >> 12);
    y = (64'(beta_reg) * lg) >> 14;
    n = y >> 16;
    g = y & 64'hFFFF;
    t = 64'd65536 - g;
    idx = int'(t >> 12);
    if (idx >= 16) pw = exp_tbl(16);
    else pw = exp_tbl(idx) + ((64'(exp_tbl(idx + 1) - exp_tbl(idx)) * (t & 64'hFFF)) >> 12);
    mag = x < 0 ? 64'(-32'(x)) : 64'(x);
    shift = 64'd17 + n;
    if (shift >= 64) res = 0;
    else res = (mag * pw + (64'd1 << (shift - 1))) >> shift;
    if (res > 64'd32768) res = 64'd32768;
    if (x < 0) return 16'(-res);
    if (res > 64'd32767) res = 64'd32767;
    return 16'(res);
  endfunction

  function automatic void clear_window();
    foreach (window_vals[i]) window_vals[i] = '0;
    sq_sum = '0;
    pending = 0;
  endfunction

  function automatic void push_value(logic signed [15:0] v, int unsigned h);
    logic [63:0] old_m, new_m;
    old_m = window_vals[2*h] < 0 ? 64'(-32'(window_vals[2*h])) : 64'(window_vals[2*h]);
    new_m = v < 0 ? 64'(-32'(v)) : 64'(v);
    for (int k = 14; k > 0; k--) window_vals[k] = window_vals[k-1];
    window_vals[0] = v;
    sq_sum = sq_sum + new_m * new_m - old_m * old_m;
  endfunction

  function automatic void predict_channel(logic signed [15:0] x, logic last);
    int unsigned h;
    int unsigned first_q;
    h = half_of_window();
    first_q = expected_q.size();
    push_value(x, h);
    if (pending >= h) expected_q.push_back(lrn_result_t'{normalize_value(window_vals[h]), 1'b0});
    else pending++;
    if (last) begin
      for (int unsigned k = 1; k <= h; k++) begin
        push_value(16'sd0, h);
        if (k > h - pending)
          expected_q.push_back(lrn_result_t'{normalize_value(window_vals[h]), 1'b0});
      end
      if (expected_q.size() > first_q) expected_q[$].last_of_run = 1'b1;
      clear_window();
    end
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.activation = '0;
    in_ch.last_channel = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  // valid stays up after an accept so that a back-to-back item only
  // replaces the payload; idle gaps and drains take it down
  task automatic send_channel(logic signed [15:0] x, logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.activation <= x;
    in_ch.last_channel <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_channel(x, last);
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
    drain_results();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_WINDOW: begin
        win_reg = value[3:0];
        clear_window();
      end
      CFG_ALPHA: alpha_reg = value;
      CFG_BETA:  beta_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_run(int n, int mode);
    logic signed [15:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = 16'($urandom_range(0, 1023)) - 16'sd512;
        default: v = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
      endcase
      send_channel(v, i == n - 1);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %0d/%0b", $time, out_ch.normalized,
                   out_ch.last_of_run);
          errors <= errors + 1;
        end else begin
          lrn_result_t e;
          e = expected_q.pop_front();
          if (e.normalized !== out_ch.normalized || e.last_of_run !== out_ch.last_of_run) begin
            $display("%0t: mismatch expected %0d/%0b actual %0d/%0b", $time, e.normalized,
                     e.last_of_run, out_ch.normalized, out_ch.last_of_run);
            errors <= errors + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic test_directed();
    send_channel(16'sh7fff, 1'b1);
    send_channel(16'sh8000, 1'b1);
    send_channel(16'sh0100, 1'b0);
    send_channel(16'sh8000, 1'b0);
    send_channel(16'sh7fff, 1'b0);
    send_channel(16'sh0000, 1'b0);
    send_channel(16'shffff, 1'b1);
    send_channel(16'sh0001, 1'b0);
    send_channel(16'sh5555, 1'b1);
    send_channel(16'shaaaa, 1'b0);
    send_channel(16'sh0200, 1'b0);
    send_channel(16'sh3c3c, 1'b0);
    send_channel(16'shc3c3, 1'b0);
    send_channel(16'sh0080, 1'b1);
  endtask

  task automatic test_windows();
    write_reg(CFG_WINDOW, 24'd0);
    send_run(3, 1);
    write_reg(CFG_WINDOW, 24'd4);
    send_run(5, 0);
    send_channel(16'sh1234, 1'b0);
    write_reg(CFG_WINDOW, 24'd15);
    send_run(2, 2);
    send_run(9, 0);
    write_reg(CFG_WINDOW, 24'd3);
    send_run(1, 0);
  endtask

  task automatic test_extremes();
    write_reg(CFG_ALPHA, 24'hffffff);
    write_reg(CFG_BETA, 24'hffff);
    send_run(4, 2);
    send_run(4, 0);
    write_reg(CFG_ALPHA, 24'd0);
    write_reg(CFG_BETA, 24'd0);
    send_run(4, 0);
    write_reg(CFG_BETA, 24'h8000);
    write_reg(CFG_ALPHA, 24'h0fffff);
    send_run(5, 1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    send_run(12, 0);
    drain_results();
    send_run(3, 0);
  endtask

  task automatic test_random(int total);
    int sent;
    sent = 0;
    while (sent < total) begin
      int n;
      n = $urandom_range(1, 10);
      if ($urandom_range(7) == 0) begin
        write_reg(CFG_WINDOW, 24'($urandom_range(0, 15)));
        write_reg(CFG_ALPHA, 24'($urandom));
        write_reg(CFG_BETA, 24'($urandom_range(0, 65535)));
      end
      send_run(n, $urandom_range(2));
      sent += n;
    end
  endtask

  initial begin
    win_reg = WS_RESET;
    alpha_reg = ALPHA_RESET;
    beta_reg = BETA_RESET;
    clear_window();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 65;
    test_directed();
    test_windows();
    test_extremes();
    send_idle_pct = 65;
    recv_idle_pct = 28;
    test_backpressure();
    test_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(30);
    drain_results();
    $display("covered %0d channel items and %0d results over window, alpha and beta",
             items_sent, results_seen);
    $display("settings incl. extremes, long output stall and random handshake gaps");
    if (errors == 0) $display("tb_lrn_across_channels passed");
    else $display("tb_lrn_across_channels failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_lrn_across_channels failed");
    $finish;
  end

endmodule
